/* rtl/core/moving_median_filter_unit_macros.svh */
// Assertion macros for the moving median filter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MOVING_MEDIAN_FILTER_UNIT_MACROS_SVH
`define MOVING_MEDIAN_FILTER_UNIT_MACROS_SVH

// Clocked implication check, disabled during reset.
`define MMF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication check, disabled during reset.
`define MMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mmf_pkg.sv */
// Shared types and constants for the moving median filter.
// No dependencies.
`timescale 1ns / 1ps

package mmf_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int DATA_W     = 64;

    localparam logic [CNT_W-1:0] WL_RESET = CNT_W'(10);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         slot;
        logic signed [DATA_W-1:0] key;
    } cell_t;

    localparam cell_t CELL_EMPTY = '0;

    typedef struct packed {
        logic                     clear;
        logic                     insert;
        logic                     full;
        logic [CNT_W-1:0]         fill;
        logic [IDX_W-1:0]         slot;
        logic signed [DATA_W-1:0] key;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SEL,
        ST_ADD,
        ST_HALF,
        ST_OUT
    } state_t;

endpackage

/* rtl/core/mmf_cell.sv */
// One cell of the sorted sample chain: holds a sample and its ring slot.
// Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mmf_pkg::cell_ctl_t          ctl,
    input  logic [mmf_pkg::IDX_W-1:0]   idx,
    input  mmf_pkg::cell_t              left,
    input  mmf_pkg::cell_t              right,
    input  logic                        swap_l,
    input  logic                        swap_r,
    output mmf_pkg::cell_t              cur,
    output logic                        gt_right
);

    logic                                valid_reg, valid_next;
    logic [mmf_pkg::IDX_W-1:0]           slot_reg, slot_next;
    logic signed [mmf_pkg::DATA_W-1:0]   key_reg, key_next;
    logic                                take_new;

    assign cur.valid = valid_reg;
    assign cur.slot  = slot_reg;
    assign cur.key   = key_reg;

    assign gt_right = valid_reg && right.valid && (key_reg > right.key);

    always_comb
    begin
        take_new = ctl.full ? (valid_reg && (slot_reg == ctl.slot))
                            : ({1'b0, idx} == ctl.fill);
        valid_next = valid_reg;
        slot_next  = slot_reg;
        key_next   = key_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.insert && take_new)
        begin
            valid_next = 1'b1;
            slot_next  = ctl.slot;
            key_next   = ctl.key;
        end
        else if (swap_r)
        begin
            slot_next = right.slot;
            key_next  = right.key;
        end
        else if (swap_l)
        begin
            slot_next = left.slot;
            key_next  = left.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        key_reg  <= key_next;
    end

endmodule

/* rtl/core/mmf_mean.sv */
// Median output stage: latches the two middle values, sums in 65 bits,
// halves toward zero (odd count: lower value). Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_mean (
    input  logic                              clk,
    input  logic                              load_sel,
    input  logic                              load_add,
    input  logic                              load_half,
    input  logic                              odd,
    input  logic signed [mmf_pkg::DATA_W-1:0] lo_val,
    input  logic signed [mmf_pkg::DATA_W-1:0] hi_val,
    output logic signed [mmf_pkg::DATA_W-1:0] median
);

    logic signed [mmf_pkg::DATA_W-1:0] a_reg, a_next;
    logic signed [mmf_pkg::DATA_W-1:0] b_reg, b_next;
    logic                              odd_reg, odd_next;
    logic signed [mmf_pkg::DATA_W:0]   sum_reg, sum_next;
    logic signed [mmf_pkg::DATA_W:0]   sum_adj;
    logic signed [mmf_pkg::DATA_W-1:0] med_reg, med_next;

    assign median = med_reg;

    always_comb
    begin
        a_next   = load_sel ? lo_val : a_reg;
        b_next   = load_sel ? hi_val : b_reg;
        odd_next = load_sel ? odd : odd_reg;
        sum_next = load_add ? ({a_reg[mmf_pkg::DATA_W-1], a_reg}
                               + {b_reg[mmf_pkg::DATA_W-1], b_reg}) : sum_reg;
        // round toward zero: bias negative sums by one before the shift
        sum_adj  = sum_reg + {{mmf_pkg::DATA_W{1'b0}}, sum_reg[mmf_pkg::DATA_W]};
        med_next = med_reg;
        if (load_half)
        begin
            med_next = odd_reg ? a_reg : sum_adj[mmf_pkg::DATA_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        odd_reg <= odd_next;
        sum_reg <= sum_next;
        med_reg <= med_next;
    end

endmodule

/* rtl/core/moving_median_filter_unit.sv */
// Sequence: an add transfer writes the sample into the cell chain at the accepting edge, then
// 16 odd-even sort passes, select, sum and halve run before out_valid rises. A clear empties the window.
// Flow: a new transfer is accepted only in idle, so an add waits until the previous result is taken.
// Reset: window empty, window length 10, no result pending.
// Depends on mmf_pkg, mmf_cell, mmf_mean and the assertion macro header.
`timescale 1ns / 1ps
`include "moving_median_filter_unit_macros.svh"

module moving_median_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mmf_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic signed [mmf_pkg::DATA_W-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mmf_pkg::DATA_W-1:0] median,
    output logic [mmf_pkg::CNT_W-1:0]         fill_count
);

    mmf_pkg::state_t                state_reg, state_next;
    logic [mmf_pkg::CNT_W-1:0]      wl_reg, wl_next;
    logic [mmf_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic [mmf_pkg::IDX_W-1:0]      wslot_reg, wslot_next;
    logic [mmf_pkg::IDX_W-1:0]      cnt_reg, cnt_next;
    logic [mmf_pkg::CNT_W-1:0]      eff_len;
    logic [mmf_pkg::CNT_W-1:0]      wslot_inc;
    logic                           full;
    logic                           in_xfer;
    logic                           sort_en;
    logic                           load_sel, load_add, load_half;
    logic [mmf_pkg::IDX_W-1:0]      lo_idx, hi_idx;
    logic [mmf_pkg::CNT_W-1:0]      fill_m1;
    logic signed [mmf_pkg::DATA_W-1:0] lo_val, hi_val;
    logic [mmf_pkg::WINDOW_MAX-1:0] valid_vec;

    mmf_pkg::cell_ctl_t             ctl;
    mmf_pkg::cell_t                 cells [mmf_pkg::WINDOW_MAX];
    logic [mmf_pkg::WINDOW_MAX-1:0] gt;

    assign in_ready   = (state_reg == mmf_pkg::ST_IDLE);
    assign out_valid  = (state_reg == mmf_pkg::ST_OUT);
    assign fill_count = fill_reg;
    assign in_xfer    = in_valid && in_ready;
    assign sort_en    = (state_reg == mmf_pkg::ST_SORT);
    assign load_sel   = (state_reg == mmf_pkg::ST_SEL);
    assign load_add   = (state_reg == mmf_pkg::ST_ADD);
    assign load_half  = (state_reg == mmf_pkg::ST_HALF);

    always_comb
    begin
        if (wl_reg == '0)
            eff_len = mmf_pkg::CNT_W'(1);
        else if (wl_reg > mmf_pkg::CNT_W'(mmf_pkg::WINDOW_MAX))
            eff_len = mmf_pkg::CNT_W'(mmf_pkg::WINDOW_MAX);
        else
            eff_len = wl_reg;
    end

    assign full      = (fill_reg >= eff_len);
    assign wslot_inc = {1'b0, wslot_reg} + mmf_pkg::CNT_W'(1);

    always_comb
    begin
        ctl.clear  = cfg_wr_en || (in_xfer && (operation == mmf_pkg::OP_CLEAR));
        ctl.insert = in_xfer && (operation == mmf_pkg::OP_ADD);
        ctl.full   = full;
        ctl.fill   = fill_reg;
        ctl.slot   = wslot_reg;
        ctl.key    = sample;
    end

    generate
        for (genvar i = 0; i < mmf_pkg::WINDOW_MAX; i++)
        begin : g_cell
            mmf_pkg::cell_t left_c, right_c;
            logic           swap_l, swap_r;
            if (i == 0)
            begin : g_first
                assign left_c = mmf_pkg::CELL_EMPTY;
                assign swap_l = 1'b0;
            end
            else
            begin : g_mid_l
                assign left_c = cells[i-1];
                assign swap_l = sort_en && (cnt_reg[0] == !i[0]) && gt[i-1];
            end
            if (i == mmf_pkg::WINDOW_MAX - 1)
            begin : g_last
                assign right_c = mmf_pkg::CELL_EMPTY;
                assign swap_r  = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_c = cells[i+1];
                assign swap_r  = sort_en && (cnt_reg[0] == i[0]) && gt[i];
            end
            mmf_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .idx      (mmf_pkg::IDX_W'(i)),
                .left     (left_c),
                .right    (right_c),
                .swap_l   (swap_l),
                .swap_r   (swap_r),
                .cur      (cells[i]),
                .gt_right (gt[i])
            );
            assign valid_vec[i] = cells[i].valid;
        end
    endgenerate

    // middle taps: lower at (n-1)/2, upper at n/2
    assign fill_m1 = fill_reg - mmf_pkg::CNT_W'(1);
    assign lo_idx  = fill_m1[mmf_pkg::CNT_W-1:1];
    assign hi_idx  = fill_reg[mmf_pkg::CNT_W-1:1];

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < mmf_pkg::WINDOW_MAX; i++)
        begin
            lo_val = lo_val | (cells[i].key
                     & {mmf_pkg::DATA_W{lo_idx == mmf_pkg::IDX_W'(i)}});
            hi_val = hi_val | (cells[i].key
                     & {mmf_pkg::DATA_W{hi_idx == mmf_pkg::IDX_W'(i)}});
        end
    end

    mmf_mean u_mean (
        .clk       (clk),
        .load_sel  (load_sel),
        .load_add  (load_add),
        .load_half (load_half),
        .odd       (fill_reg[0]),
        .lo_val    (lo_val),
        .hi_val    (hi_val),
        .median    (median)
    );

    always_comb
    begin
        state_next = state_reg;
        wl_next    = wl_reg;
        fill_next  = fill_reg;
        wslot_next = wslot_reg;
        cnt_next   = cnt_reg;
        if (cfg_wr_en)
        begin
            wl_next    = cfg_wr_data;
            fill_next  = '0;
            wslot_next = '0;
        end
        case (state_reg)
            mmf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == mmf_pkg::OP_CLEAR)
                    begin
                        fill_next  = '0;
                        wslot_next = '0;
                    end
                    else
                    begin
                        if (!full)
                            fill_next = fill_reg + mmf_pkg::CNT_W'(1);
                        if (wslot_inc == eff_len)
                            wslot_next = '0;
                        else
                            wslot_next = wslot_inc[mmf_pkg::IDX_W-1:0];
                        cnt_next   = '0;
                        state_next = mmf_pkg::ST_SORT;
                    end
                end
            end
            mmf_pkg::ST_SORT:
            begin
                cnt_next = cnt_reg + mmf_pkg::IDX_W'(1);
                if (cnt_reg == mmf_pkg::IDX_W'(mmf_pkg::WINDOW_MAX - 1))
                    state_next = mmf_pkg::ST_SEL;
            end
            mmf_pkg::ST_SEL:
            begin
                state_next = mmf_pkg::ST_ADD;
            end
            mmf_pkg::ST_ADD:
            begin
                state_next = mmf_pkg::ST_HALF;
            end
            mmf_pkg::ST_HALF:
            begin
                state_next = mmf_pkg::ST_OUT;
            end
            mmf_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = mmf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmf_pkg::ST_IDLE;
            wl_reg    <= mmf_pkg::WL_RESET;
            fill_reg  <= '0;
            wslot_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wl_reg    <= wl_next;
            fill_reg  <= fill_next;
            wslot_reg <= wslot_next;
            cnt_reg   <= cnt_next;
        end
    end

    `MMF_ASSERT_IMPL(a_fill_range, out_valid,
        (fill_count != '0) && (fill_count <= eff_len), "fill count out of window range")
    `MMF_ASSERT_IMPL(a_cells_match_fill, state_reg == mmf_pkg::ST_IDLE,
        $countones(valid_vec) == fill_reg, "occupied cells differ from fill count")
    `MMF_ASSERT_NEXT(a_add_starts_sort, in_xfer && (operation == mmf_pkg::OP_ADD),
        sort_en && (cnt_reg == '0), "add transfer did not start sort passes")
    `MMF_ASSERT_IMPL(a_slot_in_window, 1'b1,
        {1'b0, wslot_reg} < eff_len, "write slot outside window")

endmodule

/* sim/moving_median_filter_unit_tb.sv */
// Self-checking testbench for moving_median_filter_unit: directed table, then random phases.
// Depends on mmf_pkg and the moving_median_filter_unit RTL; the window median is predicted here.
`timescale 1ns / 1ps

module moving_median_filter_unit_tb;
    import mmf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 100;
    localparam int DIR_N       = 25;

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] median;
        logic [CNT_W-1:0]         fill;
    } median_res_t;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] smp;
        logic                     typed;
        logic signed [DATA_W-1:0] med;
        logic [CNT_W-1:0]         fill;
    } dir_row_t;

    // typed rows carry a fixed expectation, the rest go through the predictor
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        '{OP_ADD,   64'sd5,  1'b1, 64'sd5,  5'd1},
        '{OP_ADD,   S_MAX,   1'b0, 64'sd0,  5'd0},
        '{OP_CLEAR, 64'sd0,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   S_MIN,   1'b1, S_MIN,   5'd1},
        '{OP_ADD,   S_MIN,   1'b1, S_MIN,   5'd2},
        '{OP_ADD,   S_MAX,   1'b1, S_MIN,   5'd3},
        '{OP_CLEAR, -64'sd1, 1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   S_MAX,   1'b1, S_MAX,   5'd1},
        '{OP_ADD,   S_MIN,   1'b1, 64'sd0,  5'd2},
        '{OP_CLEAR, S_MAX,   1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   -64'sd3, 1'b1, -64'sd3, 5'd1},
        '{OP_ADD,   64'sd0,  1'b1, -64'sd1, 5'd2},
        '{OP_ADD,   64'sd3,  1'b1, 64'sd0,  5'd3},
        '{OP_ADD,   -64'sd1, 1'b0, 64'sd0,  5'd0},
        '{OP_CLEAR, S_MIN,   1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd7,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd7,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   -64'sd7, 1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd7,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd2,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd7,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd9,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   -64'sd7, 1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd7,  1'b0, 64'sd0,  5'd0},
        '{OP_ADD,   64'sd0,  1'b0, 64'sd0,  5'd0}
    };

    localparam logic [CNT_W-1:0] PHASE_LEN [N_PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd15, 5'd3, 5'd10, 5'd8
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CNT_W-1:0]         cfg_wr_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     operation;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] median;
    logic [CNT_W-1:0]         fill_count;

    moving_median_filter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median      (median),
        .fill_count  (fill_count)
    );

    median_res_t              pending_medians[$];
    int                       fault_cnt;
    int                       idle_cycles;
    int                       send_idle;
    int                       recv_stall;

    logic [CNT_W-1:0]         win_len_reg;
    logic signed [DATA_W-1:0] win_ring [WINDOW_MAX];
    int                       win_filled;
    int                       win_slot;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int win_eff_len();
        if (win_len_reg == 0)
            return 1;
        if (win_len_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(win_len_reg);
    endfunction

    task automatic window_clear();
        win_filled = 0;
        win_slot   = 0;
    endtask

    task automatic window_add(input logic signed [DATA_W-1:0] s, output median_res_t r);
        int                       len;
        int                       j;
        int                       m;
        logic signed [DATA_W-1:0] sorted [WINDOW_MAX];
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W:0]   sum;
        len = win_eff_len();
        win_ring[win_slot] = s;
        if (win_filled < len)
            win_filled++;
        win_slot = (win_slot + 1) % len;
        for (int i = 0; i < win_filled; i++)
        begin
            t = win_ring[i];
            j = i;
            while (j > 0 && sorted[j-1] > t)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = t;
        end
        m = win_filled / 2;
        if (win_filled % 2 == 1)
            r.median = sorted[m];
        else
        begin
            sum = {sorted[m-1][DATA_W-1], sorted[m-1]} + {sorted[m][DATA_W-1], sorted[m]};
            // odd negative sum: round toward zero
            if (sum[DATA_W] && sum[0])
                sum = sum + 1;
            r.median = sum[DATA_W:1];
        end
        r.fill = CNT_W'(win_filled);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_sample();
        case ($urandom_range(9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5, 6:    return $signed(64'($urandom_range(16))) - 64'sd8;
            7:
            begin
                case ($urandom_range(3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return -64'sd1;
                    default: return 64'sd0;
                endcase
            end
            default:
            begin
                if ($urandom_range(1) == 0)
                    return S_MIN + 64'($urandom_range(7));
                return S_MAX - 64'($urandom_range(7));
            end
        endcase
    endfunction

    task automatic send_transfer(input logic op, input logic signed [DATA_W-1:0] s,
                                 input logic use_typed, input median_res_t typed_res);
        median_res_t r;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample    <= s;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_CLEAR)
            window_clear();
        else
        begin
            window_add(s, r);
            pending_medians.push_back(use_typed ? typed_res : r);
        end
    endtask

    task automatic write_window_length(input logic [CNT_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        // a trailing clear may still be in flight
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_len_reg = v;
        window_clear();
    endtask

    task automatic report_fault(input string msg);
        if (fault_cnt < 10)
            $display("%0t: %s", $realtime, msg);
        fault_cnt++;
    endtask

    always @(posedge clk)
    begin
        median_res_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_medians.size() == 0)
                    report_fault($sformatf("unexpected result median=%0d fill=%0d",
                                           median, fill_count));
                else
                begin
                    exp_r = pending_medians.pop_front();
                    if (median !== exp_r.median || fill_count !== exp_r.fill)
                        report_fault($sformatf("median exp %0d got %0d, fill exp %0d got %0d",
                                               exp_r.median, median, exp_r.fill, fill_count));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        median_res_t typed_res;
        logic        op;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        operation   = OP_ADD;
        sample      = '0;
        out_ready   = 1'b0;
        fault_cnt   = 0;
        send_idle   = 0;
        recv_stall  = 0;
        win_len_reg = WL_RESET;
        window_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_N; k++)
        begin
            typed_res.median = DIR_TABLE[k].med;
            typed_res.fill   = DIR_TABLE[k].fill;
            send_transfer(DIR_TABLE[k].op, DIR_TABLE[k].smp, DIR_TABLE[k].typed, typed_res);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_window_length(PHASE_LEN[p]);
            case (p % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 47;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 47;
                end
                default:
                begin
                    send_idle  = 20;
                    recv_stall = 20;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                op = ($urandom_range(24) == 0) ? OP_CLEAR : OP_ADD;
                send_transfer(op, rand_sample(), 1'b0, typed_res);
            end
        end

        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
